FILE: rtl/core/rlf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Receive-link failsafe package
// Shared types, phase codes, beat kinds and register indexes for the
// receive-link failsafe unit.
// ----------------------------------------------------------------------------
package rlf_pkg;

  // Beat kinds on the input channel.
  localparam logic [1:0] KIND_TICK     = 2'd0;
  localparam logic [1:0] KIND_RX_VALID = 2'd1;
  localparam logic [1:0] KIND_RX_FAIL  = 2'd2;

  // Failsafe phase codes.
  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_LOSS      = 3'd1;
  localparam logic [2:0] PH_LANDING   = 3'd2;
  localparam logic [2:0] PH_LANDED    = 3'd3;
  localparam logic [2:0] PH_MONITOR   = 3'd4;
  localparam logic [2:0] PH_RECOVERED = 3'd5;

  // Switch modes.
  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_KILL   = 2'd1;
  localparam logic [1:0] MODE_STAGE2 = 2'd2;

  // Rearm hold times in milliseconds.
  localparam logic [11:0] HOLD_KILL_MS   = 12'd1000;
  localparam logic [11:0] HOLD_DISARM_MS = 12'd3000;

  // Configuration register indexes.
  localparam logic [2:0] CFG_MONITOR_ENABLE = 3'd0;
  localparam logic [2:0] CFG_FAILURE_PERIOD = 3'd1;
  localparam logic [2:0] CFG_RECOVERY_PERIOD = 3'd2;
  localparam logic [2:0] CFG_SWITCH_MODE    = 3'd3;
  localparam logic [2:0] CFG_THROTTLE_DELAY = 3'd4;

  // Configuration reset values.
  localparam logic [15:0] RST_FAILURE_PERIOD  = 16'd600;
  localparam logic [15:0] RST_RECOVERY_PERIOD = 16'd2200;
  localparam logic [15:0] RST_THROTTLE_DELAY  = 16'd10000;

  typedef struct packed {
    logic        monitor_enable;
    logic [15:0] failure_period_ms;
    logic [15:0] recovery_period_ms;
    logic [1:0]  switch_mode;
    logic [15:0] throttle_low_delay_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic        active;
    logic        disarm;
    logic [15:0] count;
  } phase_status_t;

endpackage

FILE: rtl/core/rlf_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Receive-link failsafe configuration registers
// Holds the five setup registers, written one beat at a time by index.
// ----------------------------------------------------------------------------
module rlf_cfg_regs
  import rlf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.monitor_enable        <= 1'b0;
      cfg_q.failure_period_ms     <= RST_FAILURE_PERIOD;
      cfg_q.recovery_period_ms    <= RST_RECOVERY_PERIOD;
      cfg_q.switch_mode           <= MODE_NORMAL;
      cfg_q.throttle_low_delay_ms <= RST_THROTTLE_DELAY;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_MONITOR_ENABLE:  cfg_q.monitor_enable        <= cfg_data_i[0];
        CFG_FAILURE_PERIOD:  cfg_q.failure_period_ms     <= cfg_data_i;
        CFG_RECOVERY_PERIOD: cfg_q.recovery_period_ms    <= cfg_data_i;
        CFG_SWITCH_MODE:     cfg_q.switch_mode           <= cfg_data_i[1:0];
        CFG_THROTTLE_DELAY:  cfg_q.throttle_low_delay_ms <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/rlf_link_track.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Receive-link failsafe link tracker
// Link-up hysteresis driven by receive-valid and receive-failed beats.
// ----------------------------------------------------------------------------
module rlf_link_track
  import rlf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        upd_i,
  input  logic [1:0]  kind_i,
  input  logic [31:0] now_i,
  input  cfg_t        cfg_i,
  output logic        link_q_o,
  output logic        link_d_o,
  output logic        permit_d_o
);

  logic        link_q, link_d;
  logic        permit_q, permit_d;
  logic [31:0] good_q, good_d;
  logic [31:0] fail_q, fail_d;
  logic [31:0] since_fail, since_good;

  // Wrapping time differences against the last opposite event.
  assign since_fail = now_i - fail_q;
  assign since_good = now_i - good_q;

  always_comb begin
    link_d   = link_q;
    permit_d = permit_q;
    good_d   = good_q;
    fail_d   = fail_q;
    if (upd_i) begin
      case (kind_i)
        KIND_RX_VALID: begin
          good_d = now_i;
          if (since_fail > {16'd0, cfg_i.recovery_period_ms}) begin
            link_d   = 1'b1;
            permit_d = 1'b1;
          end
        end
        KIND_RX_FAIL: begin
          permit_d = 1'b0;
          fail_d   = now_i;
          if (since_good > {16'd0, cfg_i.failure_period_ms}) begin
            link_d = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q   <= 1'b0;
      permit_q <= 1'b0;
      good_q   <= 32'd0;
      fail_q   <= 32'd0;
    end else begin
      link_q   <= link_d;
      permit_q <= permit_d;
      good_q   <= good_d;
      fail_q   <= fail_d;
    end
  end

  assign link_q_o   = link_q;
  assign link_d_o   = link_d;
  assign permit_d_o = permit_d;

endmodule

FILE: rtl/core/rlf_phase_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Receive-link failsafe phase machine
// Resolves a whole update tick, including every re-pass through the phases,
// in one step of flat logic and updates the phase state.
// ----------------------------------------------------------------------------
module rlf_phase_fsm
  import rlf_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          tick_i,
  input  logic [31:0]   now_i,
  input  logic          armed_i,
  input  logic          throttle_low_i,
  input  logic          link_i,
  input  cfg_t          cfg_i,
  output phase_status_t status_o
);

  logic [2:0]  phase_q, phase_d;
  logic        active_q, active_d;
  logic [15:0] count_q, count_d;
  logic [11:0] hold_q, hold_d;
  logic [31:0] td_q, td_d;
  logic [31:0] rd_q, rd_d;
  logic        disarm;

  logic        rx, kill_mode;
  logic        c_dly, c_kill, c_dis, c_hold;
  logic [31:0] sum_dly, sum_kill, sum_dis, sum_hold;
  logic        gt_td_q, gt_rd_q;

  logic        run_idle, from_idle, activate, do_land;
  logic        sel_kill, sel_dis;
  logic [31:0] td1, land_sum;
  logic        gt, land_carry;

  assign rx        = link_i && (cfg_i.switch_mode != MODE_STAGE2);
  assign kill_mode = (cfg_i.switch_mode == MODE_KILL);

  // A carry out of now + x means the wrapped sum lies below now, which is
  // exactly the deadline test now > (now + x).
  assign {c_dly, sum_dly}   = {1'b0, now_i} + {17'd0, cfg_i.throttle_low_delay_ms};
  assign {c_kill, sum_kill} = {1'b0, now_i} + {21'd0, HOLD_KILL_MS};
  assign {c_dis, sum_dis}   = {1'b0, now_i} + {21'd0, HOLD_DISARM_MS};
  assign {c_hold, sum_hold} = {1'b0, now_i} + {21'd0, hold_q};
  assign gt_td_q            = now_i > td_q;
  assign gt_rd_q            = now_i > rd_q;

  always_comb begin
    phase_d  = phase_q;
    active_d = active_q;
    count_d  = count_q;
    hold_d   = hold_q;
    td_d     = td_q;
    rd_d     = rd_q;
    disarm   = 1'b0;
    activate = 1'b0;
    do_land  = 1'b0;
    sel_kill = 1'b0;
    sel_dis  = 1'b0;

    from_idle = (phase_q == PH_IDLE);
    run_idle  = from_idle || (phase_q == PH_RECOVERED) || ((phase_q == PH_LOSS) && rx);
    td1       = (armed_i && !throttle_low_i) ? sum_dly : (from_idle ? td_q : sum_dly);
    gt        = (!throttle_low_i || !from_idle) ? c_dly : gt_td_q;

    if (run_idle) begin
      // Recovery (directly or out of loss) clears the active flag and
      // restarts the throttle deadline before the idle pass runs.
      phase_d = PH_IDLE;
      if (!from_idle) begin
        active_d = 1'b0;
      end
      td_d = td1;
      if (!armed_i) begin
        td_d = 32'd0;
      end else if (kill_mode) begin
        activate = 1'b0 | 1'b1;
        do_land  = 1'b1;
        sel_kill = 1'b1;
      end else if (!rx) begin
        activate = 1'b1;
        if (gt) begin
          do_land = 1'b1;
          sel_dis = 1'b1;
        end else begin
          phase_d = PH_LANDED;
        end
      end
    end else begin
      case (phase_q)
        PH_LOSS: begin
          activate = 1'b1;
          phase_d  = PH_LANDED;
        end
        PH_LANDED: begin
          do_land = 1'b1;
        end
        PH_MONITOR: begin
          if (rx) begin
            if (gt_rd_q && !armed_i) begin
              phase_d  = PH_IDLE;
              active_d = 1'b0;
              td_d     = 32'd0;
            end
          end else begin
            rd_d = sum_hold;
          end
        end
        default: begin
        end
      endcase
    end

    if (activate) begin
      active_d = 1'b1;
      if (count_q != 16'hFFFF) begin
        count_d = count_q + 16'd1;
      end
    end

    land_sum   = sel_kill ? sum_kill : (sel_dis ? sum_dis : sum_hold);
    land_carry = sel_kill ? c_kill : (sel_dis ? c_dis : c_hold);

    // Landed pass: disarm, arm the rearm deadline and go monitoring. With the
    // link up and the deadline already behind, the craft recovers at once
    // and the following idle pass sees it disarmed.
    if (do_land) begin
      disarm = 1'b1;
      if (sel_kill) begin
        hold_d = HOLD_KILL_MS;
      end else if (sel_dis) begin
        hold_d = HOLD_DISARM_MS;
      end
      rd_d = land_sum;
      if (rx && land_carry) begin
        phase_d  = PH_IDLE;
        active_d = 1'b0;
        td_d     = 32'd0;
      end else begin
        phase_d = PH_MONITOR;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      active_q <= 1'b0;
      count_q  <= 16'd0;
      hold_q   <= 12'd0;
      td_q     <= 32'd0;
      rd_q     <= 32'd0;
    end else if (tick_i) begin
      phase_q  <= phase_d;
      active_q <= active_d;
      count_q  <= count_d;
      hold_q   <= hold_d;
      td_q     <= td_d;
      rd_q     <= rd_d;
    end
  end

  assign status_o.phase  = tick_i ? phase_d : phase_q;
  assign status_o.active = tick_i ? active_d : active_q;
  assign status_o.count  = tick_i ? count_d : count_q;
  assign status_o.disarm = tick_i && disarm;

endmodule

FILE: rtl/core/rx_link_failsafe_fsm_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Receive-link failsafe unit
// Tracks receive-link health with hysteresis and runs the failsafe phase
// machine on update ticks, giving one result beat for every input beat.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake               Payload
//   input     in         in_valid_i / in_stall_o kind, now_ms, armed, throttle_low
//   output    out        out_valid_o/out_stall_i link_up, arm_permit, failsafe_active,
//                                                phase_code, disarm_request, event_total
//   config    in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// A beat lands in the input register; when it advances, flat logic commits the
// state and loads the result register, so a beat can enter every cycle while
// the output is not stalled, and its result is offered from the result register.
// The logic depth is set by the tick resolution: four 32-bit adds with carries and
// two 32-bit compares. While both registers hold a beat, an output stall stalls the
// input in that same cycle. Reset gives link down, phase idle and the default
// register values; no clearing pass. The configuration port is always ready.
// ----------------------------------------------------------------------------
module rx_link_failsafe_fsm_unit
  import rlf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [31:0] now_ms_i,
  input  logic        armed_i,
  input  logic        throttle_low_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        link_up_o,
  output logic        arm_permit_o,
  output logic        failsafe_active_o,
  output logic [2:0]  phase_code_o,
  output logic        disarm_request_o,
  output logic [15:0] event_total_o,

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  cfg_t          cfg;
  phase_status_t status;

  // Input register.
  logic        in_valid_q;
  logic [1:0]  kind_q;
  logic [31:0] now_q;
  logic        armed_q;
  logic        thr_low_q;

  // Result register.
  logic        out_valid_q;
  logic        link_up_q;
  logic        permit_q;
  logic        active_q;
  logic [2:0]  phase_q;
  logic        disarm_q;
  logic [15:0] total_q;

  logic advance;
  logic tick;
  logic link_cur, link_next, permit_next;

  // A beat moves from the input register into the result register when the
  // result register is empty or is being drained this cycle. The state
  // modules commit on that same edge.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign tick       = advance && (kind_q == KIND_TICK) && cfg.monitor_enable;

  rlf_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  rlf_link_track u_link (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .upd_i      (advance),
    .kind_i     (kind_q),
    .now_i      (now_q),
    .cfg_i      (cfg),
    .link_q_o   (link_cur),
    .link_d_o   (link_next),
    .permit_d_o (permit_next)
  );

  rlf_phase_fsm u_phase (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .tick_i         (tick),
    .now_i          (now_q),
    .armed_i        (armed_q),
    .throttle_low_i (thr_low_q),
    .link_i         (link_cur),
    .cfg_i          (cfg),
    .status_o       (status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      kind_q    <= kind_i;
      now_q     <= now_ms_i;
      armed_q   <= armed_i;
      thr_low_q <= throttle_low_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      link_up_q <= link_next;
      permit_q  <= permit_next;
      active_q  <= status.active;
      phase_q   <= status.phase;
      disarm_q  <= status.disarm;
      total_q   <= status.count;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign link_up_o         = link_up_q;
  assign arm_permit_o      = permit_q;
  assign failsafe_active_o = active_q;
  assign phase_code_o      = phase_q;
  assign disarm_request_o  = disarm_q;
  assign event_total_o     = total_q;

endmodule
